FILE: rtl/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared types, codes and tables for the MPEG audio header decoder: status
// codes, bitrate table, decoded field bundle and frame length coefficients.
// ----------------------------------------------------------------------------
package mahd_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SYNC     = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_LAYER   = 3'd3,
    ST_BAD_BITRATE = 3'd4,
    ST_BAD_RATE    = 3'd5,
    ST_FREE_FORMAT = 3'd6
  } status_t;

  // bitrate table columns
  typedef enum logic [2:0] {
    COL_V1_L1  = 3'd0,
    COL_V1_L2  = 3'd1,
    COL_V1_L3  = 3'd2,
    COL_V2_L1  = 3'd3,
    COL_V2_L23 = 3'd4
  } kbps_col_t;

  // frame length classes
  typedef enum logic [1:0] {
    LEN_SLOT4 = 2'd0,
    LEN_C144  = 2'd1,
    LEN_C72   = 2'd2
  } len_kind_t;

  localparam logic [1:0] VCODE_MPEG1    = 2'b11;
  localparam logic [1:0] VCODE_MPEG2    = 2'b10;
  localparam logic [1:0] VCODE_MPEG25   = 2'b00;
  localparam logic [1:0] VCODE_RESERVED = 2'b01;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_I    = 2'd1;
  localparam logic [1:0] LAYER_III  = 2'd3;

  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;
  localparam logic [1:0] RIDX_BAD  = 2'd3;

  localparam logic [10:0] FRAME_MAX = 11'd2047;

  // reciprocals scaled by 2^RECIP_SHIFT, exact floor for numerators below 2^17
  localparam int          RECIP_SHIFT = 26;
  localparam int          NUM_W       = 17;
  localparam int          RECIP_W     = 27;
  localparam int          Q_W         = 17;
  localparam logic [26:0] RECIP_49    = 27'd1369569;
  localparam logic [26:0] RECIP_147   = 27'd456523;
  localparam logic [26:0] RECIP_DIV1  = 27'h400_0000;
  localparam logic [26:0] RECIP_DIV2  = 27'h200_0000;
  localparam logic [26:0] RECIP_DIV4  = 27'h100_0000;
  localparam logic [26:0] RECIP_DIV8  = 27'h080_0000;

  localparam logic [8:0] KBPS_V1_L1 [16] = '{
    0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{
    0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{
    0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{
    0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};

  typedef struct packed {
    status_t     status;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padded;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [2:0]  flag_bits;
    logic [1:0]  emphasis;
  } hdr_fields_t;

  typedef struct packed {
    logic [7:0]         mult;
    logic [RECIP_W-1:0] recip;
  } len_coef_t;

  typedef struct packed {
    logic      en;
    logic      slot4;
    len_coef_t coef;
  } len_calc_t;

  function automatic logic [8:0] kbps_lookup(input logic [3:0] idx, input kbps_col_t col);
    logic [8:0] val;
    case (col)
      COL_V1_L1:  val = KBPS_V1_L1[idx];
      COL_V1_L2:  val = KBPS_V1_L2[idx];
      COL_V1_L3:  val = KBPS_V1_L3[idx];
      COL_V2_L1:  val = KBPS_V2_L1[idx];
      COL_V2_L23: val = KBPS_V2_L23[idx];
      default:    val = 9'd0;
    endcase
    return val;
  endfunction

  function automatic logic [15:0] base_rate(input logic [1:0] ridx);
    logic [15:0] val;
    case (ridx)
      2'd0:    val = 16'd44100;
      2'd1:    val = 16'd48000;
      2'd2:    val = 16'd32000;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

  // frame slots = floor(kbps * mult * 2^version * recip / 2^RECIP_SHIFT), before padding
  function automatic len_coef_t len_coef(input logic [1:0] ridx, input len_kind_t kind);
    len_coef_t c;
    c = '0;
    case (ridx)
      2'd0: begin
        case (kind)
          LEN_SLOT4: c = '{mult: 8'd40,  recip: RECIP_147};
          LEN_C144:  c = '{mult: 8'd160, recip: RECIP_49};
          LEN_C72:   c = '{mult: 8'd80,  recip: RECIP_49};
          default:   c = '0;
        endcase
      end
      2'd1: begin
        case (kind)
          LEN_SLOT4: c = '{mult: 8'd1, recip: RECIP_DIV4};
          LEN_C144:  c = '{mult: 8'd3, recip: RECIP_DIV1};
          LEN_C72:   c = '{mult: 8'd3, recip: RECIP_DIV2};
          default:   c = '0;
        endcase
      end
      2'd2: begin
        case (kind)
          LEN_SLOT4: c = '{mult: 8'd3, recip: RECIP_DIV8};
          LEN_C144:  c = '{mult: 8'd9, recip: RECIP_DIV2};
          LEN_C72:   c = '{mult: 8'd9, recip: RECIP_DIV4};
          default:   c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/mahd_if.sv
// ----------------------------------------------------------------------------
// mahd_hdr_if / mahd_res_if
// Valid/ready channels carrying header words in and decoded results out.
// ----------------------------------------------------------------------------
interface mahd_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;

  modport source (output valid, output header_word, input ready);
  modport sink   (input valid, input header_word, output ready);
endinterface

interface mahd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  version;
  logic [1:0]  layer;
  logic        crc_present;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [10:0] frame_bytes;
  logic        padded;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [2:0]  flag_bits;
  logic [1:0]  emphasis;

  modport source (
    output valid, output status, output version, output layer, output crc_present,
    output bitrate_kbps, output sample_rate_hz, output frame_bytes, output padded,
    output channel_mode, output mode_extension, output flag_bits, output emphasis,
    input ready
  );
  modport sink (
    input valid, input status, input version, input layer, input crc_present,
    input bitrate_kbps, input sample_rate_hz, input frame_bytes, input padded,
    input channel_mode, input mode_extension, input flag_bits, input emphasis,
    output ready
  );
endinterface

FILE: rtl/mahd_field_decode.sv
// ----------------------------------------------------------------------------
// mahd_field_decode
// Splits a header word into its fields, checks sync and reserved codes, looks
// up bitrate and sample rate, and selects the frame length coefficients.
// ----------------------------------------------------------------------------
module mahd_field_decode import mahd_pkg::*; (
  input  logic [31:0] header_word,
  output hdr_fields_t fields,
  output len_calc_t   calc
);

  always_comb begin
    logic [1:0]  vcode;
    logic [1:0]  lcode;
    logic [3:0]  bidx;
    logic [1:0]  ridx;
    logic        sync;
    logic        ver_ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    kbps_col_t   col;
    len_kind_t   kind;
    status_t     st;
    hdr_fields_t f;

    vcode  = header_word[20:19];
    lcode  = header_word[18:17];
    bidx   = header_word[15:12];
    ridx   = header_word[11:10];
    sync   = &header_word[31:21];
    ver_ok = (vcode != VCODE_RESERVED);

    case (vcode)
      VCODE_MPEG1:  ver = VER_MPEG1;
      VCODE_MPEG2:  ver = VER_MPEG2;
      VCODE_MPEG25: ver = VER_MPEG25;
      default:      ver = VER_MPEG1;
    endcase
    lay = (lcode == 2'd0) ? LAYER_NONE : 2'(3'd4 - {1'b0, lcode});

    if (ver == VER_MPEG1) begin
      case (lay)
        2'd1:    col = COL_V1_L1;
        2'd2:    col = COL_V1_L2;
        default: col = COL_V1_L3;
      endcase
    end else begin
      col = (lay == LAYER_I) ? COL_V2_L1 : COL_V2_L23;
    end

    if (!sync) st = ST_NO_SYNC;
    else if (!ver_ok) st = ST_BAD_VERSION;
    else if (lay == LAYER_NONE) st = ST_BAD_LAYER;
    else if (bidx == BIDX_BAD) st = ST_BAD_BITRATE;
    else if (ridx == RIDX_BAD) st = ST_BAD_RATE;
    else if (bidx == BIDX_FREE) st = ST_FREE_FORMAT;
    else st = ST_OK;

    f.status         = st;
    f.version        = ver;
    f.layer          = lay;
    f.crc_present    = ~header_word[16];
    f.bitrate_kbps   = (ver_ok && lay != LAYER_NONE) ? kbps_lookup(bidx, col) : 9'd0;
    f.sample_rate_hz = ver_ok ? (base_rate(ridx) >> ver) : 16'd0;
    f.padded         = header_word[9];
    f.channel_mode   = header_word[7:6];
    f.mode_extension = header_word[5:4];
    f.flag_bits      = {header_word[8], header_word[3], header_word[2]};
    f.emphasis       = header_word[1:0];

    if (!sync) begin
      f        = '0;
      f.status = ST_NO_SYNC;
    end
    fields = f;

    if (lay == LAYER_I) kind = LEN_SLOT4;
    else if (lay == LAYER_III && ver != VER_MPEG1) kind = LEN_C72;
    else kind = LEN_C144;

    calc.en    = (st == ST_OK);
    calc.slot4 = (lay == LAYER_I);
    calc.coef  = len_coef(ridx, kind);
  end

endmodule

FILE: rtl/mpeg_audio_header_decode_core.sv
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode_core
// Pipeline: four register stages; a header word accepted into the first stage
// comes out of the fourth, the output register, as its result.
// Throughput: one header per cycle; each stage holds under back-pressure.
// Stages: decode and table lookup, coefficient multiply, reciprocal multiply,
// slot scaling and saturation into the output register.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode_core import mahd_pkg::*; (
  input logic             clk,
  input logic             rst,
  mahd_hdr_if.sink        hdr,
  mahd_res_if.source      res
);

  hdr_fields_t dec_fields;
  len_calc_t   dec_calc;

  mahd_field_decode u_decode (
    .header_word (hdr.header_word),
    .fields      (dec_fields),
    .calc        (dec_calc)
  );

  // stage registers
  logic               v1, v2, v3, v4;
  hdr_fields_t        f1, f2, f3, f4;
  len_calc_t          c1;
  logic               en2, en3;
  logic               slot2, slot3;
  logic [NUM_W-1:0]   num2;
  logic [RECIP_W-1:0] recip2;
  logic [Q_W-1:0]     q3;
  logic [10:0]        bytes4;

  logic rdy1, rdy2, rdy3, rdy4;

  logic [18:0]                num_wide;
  logic [NUM_W-1:0]           num_next;
  logic [NUM_W+RECIP_W-1:0]   prod_nr;
  logic [Q_W-1:0]             q_next;
  logic [Q_W:0]               slots;
  logic [Q_W+2:0]             len;
  logic [10:0]                bytes_next;

  assign rdy4      = !v4 || res.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign hdr.ready = rdy1;

  always_comb begin
    num_wide = 19'(f1.bitrate_kbps) * 19'(c1.coef.mult);
    num_next = NUM_W'(num_wide << f1.version);
  end

  always_comb begin
    prod_nr = (NUM_W+RECIP_W)'(num2) * (NUM_W+RECIP_W)'(recip2);
    q_next  = prod_nr[RECIP_SHIFT +: Q_W];
  end

  always_comb begin
    slots = (Q_W+1)'(q3) + (Q_W+1)'(f3.padded);
    len   = slot3 ? {slots, 2'b00} : {2'b00, slots};
    if (!en3) bytes_next = 11'd0;
    else if (len > (Q_W+3)'(FRAME_MAX)) bytes_next = FRAME_MAX;
    else bytes_next = len[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= hdr.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && hdr.valid) begin
      f1 <= dec_fields;
      c1 <= dec_calc;
    end
    if (rdy2 && v1) begin
      f2     <= f1;
      en2    <= c1.en;
      slot2  <= c1.slot4;
      num2   <= num_next;
      recip2 <= c1.coef.recip;
    end
    if (rdy3 && v2) begin
      f3    <= f2;
      en3   <= en2;
      slot3 <= slot2;
      q3    <= q_next;
    end
    if (rdy4 && v3) begin
      f4     <= f3;
      bytes4 <= bytes_next;
    end
  end

  assign res.valid          = v4;
  assign res.status         = f4.status;
  assign res.version        = f4.version;
  assign res.layer          = f4.layer;
  assign res.crc_present    = f4.crc_present;
  assign res.bitrate_kbps   = f4.bitrate_kbps;
  assign res.sample_rate_hz = f4.sample_rate_hz;
  assign res.frame_bytes    = bytes4;
  assign res.padded         = f4.padded;
  assign res.channel_mode   = f4.channel_mode;
  assign res.mode_extension = f4.mode_extension;
  assign res.flag_bits      = f4.flag_bits;
  assign res.emphasis       = f4.emphasis;

  // error results carry no length
  a_err_no_len: assert property (@(posedge clk) disable iff (rst)
    v4 && f4.status != ST_OK |-> bytes4 == 11'd0)
    else $error("frame length on error status");

  // layer I frames are whole 4-byte slots
  a_slot_align: assert property (@(posedge clk) disable iff (rst)
    v4 && f4.status == ST_OK && f4.layer == LAYER_I |-> bytes4[1:0] == 2'b00)
    else $error("layer I length not slot aligned");

  // a good header always has a nonzero rate, bitrate and length
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    v4 && f4.status == ST_OK |->
      f4.sample_rate_hz != 16'd0 && f4.bitrate_kbps != 9'd0 && bytes4 != 11'd0)
    else $error("good header with zero rate or length");

  // an accepted transaction occupies the first stage on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    hdr.valid && hdr.ready |=> v1)
    else $error("accepted transaction lost at entry");

  // a stalled output stage keeps its length
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !res.ready |=> v4 && $stable(bytes4) && $stable(f4))
    else $error("stalled result changed");

endmodule
